### hw/rtl/rmbn_pkg.sv
// ----------------------------------------------------------------------------
// rmbn_pkg
// shared types and codes for the rate matrix build and normalise unit
// ----------------------------------------------------------------------------
package rmbn_pkg;

    // index and count fields in the control structs, sized for the widest alphabet
    localparam int IDX_MAX_W = 6;
    localparam int CNT_MAX_W = 7;

    typedef enum logic [1:0] {
        CMD_LOAD_FREQ = 2'd0,
        CMD_LOAD_EXCH = 2'd1,
        CMD_BUILD     = 2'd2,
        CMD_READ      = 2'd3
    } cmd_t;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BAD_INDEX = 2'd1;
    localparam logic [1:0] STAT_ZERO_SUM  = 2'd2;

    localparam logic REG_ALPHABET_SIZE = 1'b0;
    localparam logic REG_TARGET_RATE   = 1'b1;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_LD_FREQ,
        DP_LD_EXCH,
        DP_RD_RATE,
        DP_FETCH,
        DP_MUL_OD,
        DP_MUL_S,
        DP_ACC_S,
        DP_SUM_CLR,
        DP_ROW_CLR,
        DP_ACC_ROW,
        DP_MUL_X,
        DP_DIV_START,
        DP_WR_RATE
    } dp_op_t;

    typedef struct packed {
        dp_op_t               op;
        logic [IDX_MAX_W-1:0] i_idx;
        logic [IDX_MAX_W-1:0] j_idx;
        logic                 out_load;
        logic [1:0]           out_status;
        logic                 out_rate_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic [CNT_MAX_W-1:0] n;
        logic                 sum_zero;
        logic                 div_done;
    } dp_sts_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_S_INIT,
        ST_S_FETCH,
        ST_S_MUL1,
        ST_S_MUL2,
        ST_S_ACC,
        ST_S_CHECK,
        ST_R_INIT,
        ST_R_FETCH,
        ST_R_MUL,
        ST_R_ACC,
        ST_E_FETCH,
        ST_E_MUL1,
        ST_E_MULX,
        ST_E_DIV,
        ST_E_WAIT,
        ST_E_WRITE,
        ST_DONE
    } state_t;

endpackage

### hw/rtl/rmbn_div.sv
// ----------------------------------------------------------------------------
// rmbn_div
// restoring divider, one quotient bit per cycle, quotient capped at 2^32
// ----------------------------------------------------------------------------
module rmbn_div #(
    parameter int DVD_W = 71,
    parameter int DVS_W = 58
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [32:0]      quotient
);

    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [32:0] QUO_CAP = 33'h1_0000_0000;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [32:0]      quo_reg;

    logic [DVS_W:0]   rem_shift;
    logic [DVS_W:0]   rem_diff;
    logic             ge;
    logic [DVS_W-1:0] rem_next;
    logic [33:0]      quo_full;
    logic [32:0]      quo_next;

    always_comb begin
        rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
        rem_diff  = rem_shift - {1'b0, divisor};
        ge        = rem_shift >= {1'b0, divisor};
        rem_next  = ge ? rem_diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
        quo_full  = {quo_reg, ge};
        quo_next  = (quo_full > {1'b0, QUO_CAP}) ? QUO_CAP : quo_full[32:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hw/rtl/rmbn_dp.sv
// ----------------------------------------------------------------------------
// rmbn_dp
// datapath: config registers, stores, multipliers, accumulators, result register
// ----------------------------------------------------------------------------
module rmbn_dp import rmbn_pkg::*; #(
    parameter int MAX_ALPHABET = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [17:0]        cfg_wr_data,
    input  logic [4:0]         s_row,
    input  logic [4:0]         s_col,
    input  logic [15:0]        s_value,
    input  dp_cmd_t            cmd,
    output dp_sts_t            sts,
    output logic [1:0]         m_status,
    output logic signed [31:0] m_rate
);

    localparam int IDX_W  = (MAX_ALPHABET > 2) ? $clog2(MAX_ALPHABET) : 1;
    localparam int DEPTH  = MAX_ALPHABET * MAX_ALPHABET;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = 48 + 2 * IDX_W;
    localparam int ROW_W  = 32 + IDX_W;
    localparam int P_W    = ROW_W + 18;
    localparam int DVD_W  = P_W + 16;
    localparam logic [ROW_W-1:0]     ONE_Q24 = ROW_W'(1) << 24;
    localparam logic [CNT_MAX_W-1:0] MAX_N   = CNT_MAX_W'(MAX_ALPHABET);

    function automatic logic [ADDR_W-1:0] addr_of(logic [ADDR_W-1:0] r, logic [ADDR_W-1:0] c);
        return r * ADDR_W'(MAX_ALPHABET) + c;
    endfunction

    logic [5:0]  alpha_reg;
    logic [17:0] target_reg;

    logic [15:0] freq_mem [MAX_ALPHABET];
    logic [15:0] exch_mem [DEPTH];
    logic [31:0] rate_mem [DEPTH];

    logic [15:0]       fi_reg, fj_reg, ex_reg;
    logic [31:0]       rd_rate_reg;
    logic [31:0]       od_reg;
    logic [47:0]       prod_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [ROW_W-1:0]  rowsum_reg;
    logic [P_W-1:0]    p_reg;
    logic              neg_reg;
    logic [1:0]        m_status_reg;
    logic [31:0]       m_rate_reg;

    logic [IDX_W-1:0]  i_idx, j_idx, hi_idx, lo_idx;
    logic [ADDR_W-1:0] addr_ij, addr_hl, addr_rc;
    logic [CNT_MAX_W-1:0] n_eff;

    logic              f_we, e_we, r_we;
    logic [IDX_W-1:0]  f_addr;
    logic [ADDR_W-1:0] e_addr, r_addr;
    logic [15:0]       f_data, e_data;
    logic [31:0]       r_data;

    logic              is_diag, over_one;
    logic [ROW_W-1:0]  m_sel;
    logic              div_done;
    logic [32:0]       quo;
    logic [32:0]       quo_neg;
    logic [31:0]       rate_conv;

    assign i_idx   = cmd.i_idx[IDX_W-1:0];
    assign j_idx   = cmd.j_idx[IDX_W-1:0];
    assign hi_idx  = (i_idx > j_idx) ? i_idx : j_idx;
    assign lo_idx  = (i_idx > j_idx) ? j_idx : i_idx;
    assign addr_ij = addr_of(ADDR_W'(i_idx), ADDR_W'(j_idx));
    assign addr_hl = addr_of(ADDR_W'(hi_idx), ADDR_W'(lo_idx));
    assign addr_rc = addr_of(ADDR_W'(s_row), ADDR_W'(s_col));
    assign n_eff   = ({1'b0, alpha_reg} > MAX_N) ? MAX_N : CNT_MAX_W'(alpha_reg);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg  <= 6'd20;
            target_reg <= 18'd65536;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ALPHABET_SIZE: alpha_reg  <= cfg_wr_data[5:0];
                REG_TARGET_RATE:   target_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // write port selection
    always_comb begin
        f_we   = 1'b0;
        e_we   = 1'b0;
        r_we   = 1'b0;
        f_addr = j_idx;
        e_addr = addr_ij;
        r_addr = addr_ij;
        f_data = '0;
        e_data = '0;
        r_data = '0;
        case (cmd.op)
            DP_CLEAR: begin
                f_we = (i_idx == '0);
                e_we = 1'b1;
                r_we = 1'b1;
            end
            DP_LD_FREQ: begin
                f_we   = 1'b1;
                f_addr = IDX_W'(s_row);
                f_data = s_value;
            end
            DP_LD_EXCH: begin
                e_we   = 1'b1;
                e_addr = addr_rc;
                e_data = s_value;
            end
            DP_WR_RATE: begin
                r_we   = 1'b1;
                r_data = rate_conv;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (f_we) freq_mem[f_addr] <= f_data;
        if (e_we) exch_mem[e_addr] <= e_data;
        if (r_we) rate_mem[r_addr] <= r_data;
        if (cmd.op == DP_FETCH) begin
            fi_reg <= freq_mem[i_idx];
            fj_reg <= freq_mem[j_idx];
            ex_reg <= exch_mem[addr_hl];
        end
        if (cmd.op == DP_RD_RATE) rd_rate_reg <= rate_mem[addr_rc];
    end

    // magnitude and sign of the entry before scaling
    always_comb begin
        is_diag  = (i_idx == j_idx);
        over_one = rowsum_reg > ONE_Q24;
        if (!is_diag) begin
            m_sel = ROW_W'(od_reg);
        end else if (over_one) begin
            m_sel = rowsum_reg - ONE_Q24;
        end else begin
            m_sel = ONE_Q24 - rowsum_reg;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            DP_MUL_OD:  od_reg   <= fj_reg * ex_reg;
            DP_MUL_S:   prod_reg <= fi_reg * od_reg;
            DP_SUM_CLR: sum_reg  <= '0;
            DP_ACC_S: begin
                if (!is_diag) sum_reg <= sum_reg + SUM_W'(prod_reg);
            end
            DP_ROW_CLR: rowsum_reg <= '0;
            DP_ACC_ROW: begin
                if (!is_diag) rowsum_reg <= rowsum_reg + ROW_W'(od_reg);
            end
            DP_MUL_X: begin
                p_reg   <= m_sel * target_reg;
                neg_reg <= is_diag && over_one;
            end
            default: ;
        endcase
        if (cmd.out_load) begin
            m_status_reg <= cmd.out_status;
            m_rate_reg   <= cmd.out_rate_sel ? rd_rate_reg : 32'd0;
        end
    end

    rmbn_div #(
        .DVD_W (DVD_W),
        .DVS_W (SUM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.op == DP_DIV_START),
        .dividend ({p_reg, 16'h0000}),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (quo)
    );

    // truncated quotient to saturated signed q15.16
    always_comb begin
        quo_neg = (quo > 33'h0_8000_0000) ? 33'h0_8000_0000 : quo;
        if (neg_reg) begin
            rate_conv = 32'(33'd0 - quo_neg);
        end else begin
            rate_conv = (quo > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
        end
    end

    assign sts.n        = n_eff;
    assign sts.sum_zero = (sum_reg == '0);
    assign sts.div_done = div_done;
    assign m_status     = m_status_reg;
    assign m_rate       = m_rate_reg;

endmodule

### hw/rtl/rmbn_ctrl.sv
// ----------------------------------------------------------------------------
// rmbn_ctrl
// command sequencer: clearing sweep, load/read handling, build walk
// ----------------------------------------------------------------------------
module rmbn_ctrl import rmbn_pkg::*; #(
    parameter int MAX_ALPHABET = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    input  logic [4:0] s_row,
    input  logic [4:0] s_col,
    output logic       m_valid,
    input  logic       m_ready,
    output dp_cmd_t    cmd,
    input  dp_sts_t    sts
);

    localparam int IDX_W = (MAX_ALPHABET > 2) ? $clog2(MAX_ALPHABET) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_ALPHABET - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic             m_valid_reg, m_valid_next;

    logic             accept;
    logic             j_last, i_last;
    logic             row_bad, col_bad;
    logic [CNT_MAX_W-1:0] row_w, col_w;

    assign row_w   = CNT_MAX_W'(s_row);
    assign col_w   = CNT_MAX_W'(s_col);
    assign row_bad = row_w >= sts.n;
    assign col_bad = col_w >= sts.n;
    assign j_last  = (CNT_MAX_W'(j_reg) + 1'b1) >= sts.n;
    assign i_last  = (CNT_MAX_W'(i_reg) + 1'b1) >= sts.n;
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            i_reg       <= '0;
            j_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cmd        = '0;
        cmd.op     = DP_NOP;
        cmd.i_idx  = IDX_MAX_W'(i_reg);
        cmd.j_idx  = IDX_MAX_W'(j_reg);
        case (state_reg)
            ST_CLEAR: begin
                cmd.op = DP_CLEAR;
                if (j_reg == IDX_LAST) begin
                    j_next = '0;
                    if (i_reg == IDX_LAST) begin
                        i_next     = '0;
                        state_next = ST_IDLE;
                    end else begin
                        i_next = i_reg + 1'b1;
                    end
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (s_command)
                        CMD_LOAD_FREQ: begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = row_bad ? STAT_BAD_INDEX : STAT_OK;
                            if (!row_bad) cmd.op = DP_LD_FREQ;
                        end
                        CMD_LOAD_EXCH: begin
                            cmd.out_load = 1'b1;
                            if (row_bad || (s_col >= s_row)) begin
                                cmd.out_status = STAT_BAD_INDEX;
                            end else begin
                                cmd.out_status = STAT_OK;
                                cmd.op         = DP_LD_EXCH;
                            end
                        end
                        CMD_READ: begin
                            if (row_bad || col_bad) begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = STAT_BAD_INDEX;
                            end else begin
                                cmd.op     = DP_RD_RATE;
                                state_next = ST_READ;
                            end
                        end
                        CMD_BUILD: state_next = ST_S_INIT;
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                cmd.out_load     = 1'b1;
                cmd.out_status   = STAT_OK;
                cmd.out_rate_sel = 1'b1;
                state_next       = ST_IDLE;
            end
            ST_S_INIT: begin
                cmd.op     = DP_SUM_CLR;
                i_next     = '0;
                j_next     = '0;
                state_next = (sts.n == '0) ? ST_S_CHECK : ST_S_FETCH;
            end
            ST_S_FETCH: begin
                cmd.op     = DP_FETCH;
                state_next = ST_S_MUL1;
            end
            ST_S_MUL1: begin
                cmd.op     = DP_MUL_OD;
                state_next = ST_S_MUL2;
            end
            ST_S_MUL2: begin
                cmd.op     = DP_MUL_S;
                state_next = ST_S_ACC;
            end
            ST_S_ACC: begin
                cmd.op = DP_ACC_S;
                if (j_last) begin
                    j_next = '0;
                    if (i_last) begin
                        i_next     = '0;
                        state_next = ST_S_CHECK;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_S_FETCH;
                    end
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_S_FETCH;
                end
            end
            ST_S_CHECK: begin
                if (sts.sum_zero) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = STAT_ZERO_SUM;
                    state_next     = ST_IDLE;
                end else begin
                    state_next = ST_R_INIT;
                end
            end
            ST_R_INIT: begin
                cmd.op     = DP_ROW_CLR;
                state_next = ST_R_FETCH;
            end
            ST_R_FETCH: begin
                cmd.op     = DP_FETCH;
                state_next = ST_R_MUL;
            end
            ST_R_MUL: begin
                cmd.op     = DP_MUL_OD;
                state_next = ST_R_ACC;
            end
            ST_R_ACC: begin
                cmd.op = DP_ACC_ROW;
                if (j_last) begin
                    j_next     = '0;
                    state_next = ST_E_FETCH;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_R_FETCH;
                end
            end
            ST_E_FETCH: begin
                cmd.op     = DP_FETCH;
                state_next = ST_E_MUL1;
            end
            ST_E_MUL1: begin
                cmd.op     = DP_MUL_OD;
                state_next = ST_E_MULX;
            end
            ST_E_MULX: begin
                cmd.op     = DP_MUL_X;
                state_next = ST_E_DIV;
            end
            ST_E_DIV: begin
                cmd.op     = DP_DIV_START;
                state_next = ST_E_WAIT;
            end
            ST_E_WAIT: begin
                if (sts.div_done) state_next = ST_E_WRITE;
            end
            ST_E_WRITE: begin
                cmd.op = DP_WR_RATE;
                if (j_last) begin
                    j_next = '0;
                    if (i_last) begin
                        i_next     = '0;
                        state_next = ST_DONE;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_R_INIT;
                    end
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_E_FETCH;
                end
            end
            ST_DONE: begin
                cmd.out_load   = 1'b1;
                cmd.out_status = STAT_OK;
                state_next     = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

    a_out_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before it was taken");

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> (state_reg == ST_E_WAIT))
        else $error("divider finished outside the wait state");

    a_build_no_early_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_command == CMD_BUILD)) |=> !m_valid_reg)
        else $error("result beat appeared straight after a build was taken");

endmodule

### hw/rtl/rate_matrix_build_normalize_unit.sv
// ----------------------------------------------------------------------------
// rate_matrix_build_normalize_unit
// builds and normalises a reversible substitution rate matrix from loaded
// stationary frequencies and exchangeabilities, and serves its entries
// ----------------------------------------------------------------------------
// frequency and exchangeability loads give their result beat in the cycle after
//   the item is taken; reads go through one registered store read first
// build: a normalising-sum pass over the n x n block (fetch, two multiplies,
//   accumulate), then per row a row-sum pass (fetch, multiply, accumulate) and
//   per entry a fetch, two multiplies, a bit-serial divide over DVD_W dividend
//   bits (DVD_W = log2(MAX_ALPHABET) + 66, 71 at 32) and a write
// one item at a time; a new item is taken at the earliest in the cycle that
//   the previous result beat is taken
// reset: stores swept to zero, no item taken meanwhile; config writes go in as ever
// ----------------------------------------------------------------------------
module rate_matrix_build_normalize_unit import rmbn_pkg::*; #(
    parameter int MAX_ALPHABET = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write port
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [17:0]        cfg_wr_data,
    // command channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [4:0]         s_row,
    input  logic [4:0]         s_col,
    input  logic [15:0]        s_value,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [31:0] m_rate
);

    // command bundle from the sequencer, status back from the datapath
    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    // sequencer: clearing sweep, index checks, build walk over the n x n block
    rmbn_ctrl #(
        .MAX_ALPHABET (MAX_ALPHABET)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_row     (s_row),
        .s_col     (s_col),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (dp_cmd),
        .sts       (dp_sts)
    );

    // datapath: stores, multipliers, sum and row sum, divider, result register
    rmbn_dp #(
        .MAX_ALPHABET (MAX_ALPHABET)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_row       (s_row),
        .s_col       (s_col),
        .s_value     (s_value),
        .cmd         (dp_cmd),
        .sts         (dp_sts),
        .m_status    (m_status),
        .m_rate      (m_rate)
    );

endmodule

### tb/rmbn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmbn_checker
// watches the command and result channels of the rate matrix unit, keeps its
// own copy of the stores, predicts every result beat and compares in order
// ----------------------------------------------------------------------------
module rmbn_checker import rmbn_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [17:0]        cfg_wr_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [4:0]         s_row,
    input  logic [4:0]         s_col,
    input  logic [15:0]        s_value,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [1:0]         m_status,
    input  logic signed [31:0] m_rate,
    output int                 fail_count,
    output int                 pending
);

    localparam int MAXA = 32;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] rate;
    } beat_t;

    logic [5:0]  size_reg;
    logic [17:0] target_reg;
    logic [15:0] freq_mem [MAXA];
    logic [15:0] exch_mem [MAXA*MAXA];
    logic [31:0] rate_mem [MAXA*MAXA];
    beat_t       expected_beats [$];

    assign pending = expected_beats.size();

    function automatic int unsigned matrix_size();
        return (size_reg > MAXA) ? MAXA : size_reg;
    endfunction

    function automatic logic [63:0] off_entry(int i, int j);
        int h, l;
        h = (i > j) ? i : j;
        l = (i > j) ? j : i;
        return 64'(freq_mem[j]) * 64'(exch_mem[h*MAXA + l]);
    endfunction

    // truncating divide with saturation, sign from the entry
    function automatic logic [31:0] scaled(logic signed [63:0] e, logic [63:0] s);
        logic [127:0] m, q;
        logic         neg;
        neg = e < 0;
        m = neg ? 128'(-e) : 128'(e);
        q = ((m * 128'(target_reg)) << 16) / 128'(s);
        if (!neg) return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        if (q > 128'h8000_0000) q = 128'h8000_0000;
        return 32'(-q[31:0]);
    endfunction

    function automatic logic [1:0] build_matrix();
        int unsigned       n;
        logic [63:0]       s, rs;
        logic signed [63:0] e;
        n = matrix_size();
        s = 0;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                if (i != j) s += 64'(freq_mem[i]) * off_entry(i, j);
        if (s == 0) return STAT_ZERO_SUM;
        for (int i = 0; i < n; i++) begin
            rs = 0;
            for (int j = 0; j < n; j++)
                if (j != i) rs += off_entry(i, j);
            for (int j = 0; j < n; j++) begin
                e = (i == j) ? (64'sd1 <<< 24) - $signed(rs) : $signed(off_entry(i, j));
                rate_mem[i*MAXA + j] = scaled(e, s);
            end
        end
        return STAT_OK;
    endfunction

    function automatic beat_t predict_beat(cmd_t c, int r, int k, logic [15:0] v);
        beat_t b;
        int unsigned n;
        n = matrix_size();
        b = '0;
        case (c)
            CMD_LOAD_FREQ: begin
                if (r >= n) b.status = STAT_BAD_INDEX;
                else freq_mem[r] = v;
            end
            CMD_LOAD_EXCH: begin
                if (r >= n || k >= r) b.status = STAT_BAD_INDEX;
                else exch_mem[r*MAXA + k] = v;
            end
            CMD_BUILD: b.status = build_matrix();
            default: begin
                if (r >= n || k >= n) b.status = STAT_BAD_INDEX;
                else b.rate = rate_mem[r*MAXA + k];
            end
        endcase
        return b;
    endfunction

    always @(posedge aclk) begin
        beat_t want;
        if (!aresetn) begin
            size_reg   <= 6'd20;
            target_reg <= 18'd65536;
            for (int i = 0; i < MAXA*MAXA; i++) begin
                exch_mem[i] = '0;
                rate_mem[i] = '0;
            end
            for (int i = 0; i < MAXA; i++) freq_mem[i] = '0;
            expected_beats.delete();
            fail_count <= 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_ALPHABET_SIZE) size_reg <= cfg_wr_data[5:0];
                else target_reg <= cfg_wr_data;
            end
            if (m_valid && m_ready) begin
                if (expected_beats.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result beat: status %0d rate %0d",
                                 m_status, m_rate);
                end else begin
                    want = expected_beats.pop_front();
                    if (want.status !== m_status || want.rate !== m_rate) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: expected status %0d rate %0d, got %0d %0d",
                                     want.status, $signed(want.rate), m_status, m_rate);
                    end
                end
            end
            if (s_valid && s_ready)
                expected_beats.push_back(predict_beat(cmd_t'(s_command), s_row, s_col,
                                                      s_value));
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives loads, builds and reads into the rate matrix unit across several
// sizes and target rates, with bursty sending and a stalling receiver
// ----------------------------------------------------------------------------
module tb_top;
    import rmbn_pkg::*;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic               cfg_index;
    logic [17:0]        cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_command;
    logic [4:0]         s_row;
    logic [4:0]         s_col;
    logic [15:0]        s_value;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_status;
    logic signed [31:0] m_rate;
    int                 fail_count;
    int                 pending;
    bit                 hold_off_req;
    bit                 hold_off_done;

    int n_list [5] = '{2, 4, 63, 8, 32};

    rate_matrix_build_normalize_unit dut (.*);
    rmbn_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // receiver: own stall pattern, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        hold_off_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req && !hold_off_done) begin
                m_ready <= 1'b0;
                repeat (60) @(posedge aclk);
                hold_off_done = 1'b1;
            end
            case ($urandom_range(0, 3))
                0: m_ready <= 1'b0;
                default: m_ready <= 1'b1;
            endcase
        end
    end

    // generous fixed limit: builds dominate the run time, the largest at n = 32
    initial begin
        #80ms;
        $display("Simulation FAILED");
        $finish;
    end

    int gap_left;
    int burst_left;

    // one command beat, with bursts and random gaps before it
    task automatic send_beat(cmd_t c, logic [4:0] r, logic [4:0] k, logic [15:0] v);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap_left != 0) begin
                s_valid <= 1'b0;
                repeat (gap_left) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_command <= c;
        s_row     <= r;
        s_col     <= k;
        s_value   <= v;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [17:0] d);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= d;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // load frequencies and exchangeabilities for an n-symbol matrix, then build
    task automatic fill_and_build(int n, bit sparse);
        for (int i = 0; i < n; i++)
            send_beat(CMD_LOAD_FREQ, 5'(i), 5'($urandom), 16'($urandom));
        for (int i = 1; i < n; i++)
            for (int j = 0; j < i; j++)
                if (!sparse || $urandom_range(0, 3) == 0)
                    send_beat(CMD_LOAD_EXCH, 5'(i), 5'(j), 16'($urandom));
        send_beat(CMD_BUILD, 5'($urandom), 5'($urandom), 16'($urandom));
    endtask

    task automatic random_mix(int count, int n);
        int  sel;
        bit  wide;
        for (int k = 0; k < count; k++) begin
            sel  = $urandom_range(0, 99);
            wide = $urandom_range(0, 9) == 0;
            if (sel < 45)
                send_beat(CMD_READ, 5'($urandom_range(0, wide ? 31 : n - 1)),
                          5'($urandom_range(0, wide ? 31 : n - 1)), 16'($urandom));
            else if (sel < 65)
                send_beat(CMD_LOAD_FREQ, 5'($urandom_range(0, wide ? 31 : n - 1)),
                          5'($urandom), 16'($urandom));
            else if (sel < 97)
                send_beat(CMD_LOAD_EXCH, 5'($urandom), 5'($urandom), 16'($urandom));
            else
                send_beat(CMD_BUILD, 5'($urandom), 5'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        int n;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = 1'b0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_command    = '0;
        s_row        = '0;
        s_col        = '0;
        s_value      = '0;
        hold_off_req = 1'b0;
        burst_left   = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: zero sum on empty stores, bad indexes, field extremes
        write_reg(REG_ALPHABET_SIZE, 18'd3);
        send_beat(CMD_BUILD, 5'd0, 5'd0, 16'd0);
        send_beat(CMD_READ, 5'd2, 5'd2, 16'hFFFF);
        send_beat(CMD_READ, 5'd3, 5'd0, 16'd0);
        send_beat(CMD_READ, 5'd0, 5'd31, 16'd0);
        send_beat(CMD_LOAD_FREQ, 5'd31, 5'd31, 16'hFFFF);
        send_beat(CMD_LOAD_EXCH, 5'd1, 5'd1, 16'hFFFF);
        send_beat(CMD_LOAD_EXCH, 5'd31, 5'd0, 16'hFFFF);
        send_beat(CMD_LOAD_FREQ, 5'd0, 5'd0, 16'hFFFF);
        send_beat(CMD_LOAD_FREQ, 5'd1, 5'd0, 16'hFFFF);
        send_beat(CMD_LOAD_FREQ, 5'd2, 5'd0, 16'd1);
        send_beat(CMD_LOAD_EXCH, 5'd1, 5'd0, 16'hFFFF);
        send_beat(CMD_LOAD_EXCH, 5'd2, 5'd1, 16'd1);
        send_beat(CMD_BUILD, 5'd31, 5'd31, 16'hFFFF);
        for (int i = 0; i < 3; i++)
            send_beat(CMD_READ, 5'(i), 5'(i), 16'd0);
        send_beat(CMD_READ, 5'd0, 5'd1, 16'd0);
        drain();

        // extreme target rates, and size one forces a zero sum
        write_reg(REG_TARGET_RATE, 18'h3FFFF);
        send_beat(CMD_BUILD, 5'd0, 5'd0, 16'd0);
        send_beat(CMD_READ, 5'd0, 5'd0, 16'd0);
        send_beat(CMD_READ, 5'd1, 5'd0, 16'd0);
        drain();
        write_reg(REG_TARGET_RATE, 18'd0);
        send_beat(CMD_BUILD, 5'd0, 5'd0, 16'd0);
        send_beat(CMD_READ, 5'd1, 5'd0, 16'd0);
        drain();
        write_reg(REG_ALPHABET_SIZE, 18'd1);
        send_beat(CMD_BUILD, 5'd0, 5'd0, 16'd0);
        send_beat(CMD_LOAD_FREQ, 5'd1, 5'd0, 16'd5);
        drain();

        // random phases over several sizes; oversize setting acts as the maximum
        foreach (n_list[p]) begin
            write_reg(REG_ALPHABET_SIZE, 18'(n_list[p]));
            write_reg(REG_TARGET_RATE, 18'($urandom));
            n = (n_list[p] > 32) ? 32 : n_list[p];
            if (p == 1) hold_off_req = 1'b1;
            fill_and_build(n < 8 ? n : 6, 1'b0);
            random_mix(40, n);
            if (n <= 8) fill_and_build(n, $urandom_range(0, 1));
            random_mix(20, n);
            drain();
        end

        drain();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
